[rtl/lghf_pkg.sv]
// ----------------------------------------------------------------------------
// lghf_pkg: shared types and constants
// Item structs, queue entry, item classes and back-end sequencer states.
// ----------------------------------------------------------------------------
package lghf_pkg;

    localparam int unsigned CutW   = 40;  // cut level, signed, 1/65536 m
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = 2;
    localparam int unsigned QCntW  = 3;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic signed [15:0] z_pos;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
    } t_out_item;

    typedef enum logic [1:0] {
        CLS_MEASURE,    // measure word inside a measure pass
        CLS_NEW_CLOUD,  // measure word after a filter pass: clear first
        CLS_SWITCH,     // first filter word: compute cut level first
        CLS_FILTER      // filter word inside a filter pass
    } t_cls;

    typedef struct packed {
        t_cls     cls;
        t_in_item item;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [3:0] {
        ST_RUN,
        ST_W_MEAN,
        ST_MUL_A,
        ST_MUL_N,
        ST_W_RR,
        ST_DEV,
        ST_W_M256,
        ST_VAR_GO,
        ST_W_VAR
    } t_bstate;

endpackage

[rtl/lghf_front.sv]
// ----------------------------------------------------------------------------
// lghf_front: input acceptance and classification
// Tracks the pass and tags each word as measure, new cloud, switch or filter.
// ----------------------------------------------------------------------------
module lghf_front import lghf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    input  t_qstat   i_qstat,
    output logic     o_busy,
    output logic     o_push,
    output t_qent    o_qent
);

    logic r_filter_pass;
    logic n_filter_pass;

    assign o_busy = i_qstat.full;
    assign o_push = i_start && !i_qstat.full;

    always_comb begin
        o_qent.item = i_item;
        if (i_item.kind) begin
            o_qent.cls = r_filter_pass ? CLS_FILTER : CLS_SWITCH;
        end else begin
            o_qent.cls = r_filter_pass ? CLS_NEW_CLOUD : CLS_MEASURE;
        end
        n_filter_pass = o_push ? i_item.kind : r_filter_pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_pass <= 1'b0;
        end else begin
            r_filter_pass <= n_filter_pass;
        end
    end

endmodule

[rtl/lghf_fifo.sv]
// ----------------------------------------------------------------------------
// lghf_fifo: short queue between front and back
// Register-based FIFO of classified words; head is shown combinationally.
// ----------------------------------------------------------------------------
module lghf_fifo import lghf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qent  i_qent,
    input  logic   i_pop,
    output t_qent  o_head,
    output t_qstat o_qstat
);

    t_qent            r_mem [QDepth];
    logic [QPtrW-1:0] r_wr;
    logic [QPtrW-1:0] r_rd;
    logic [QCntW-1:0] r_cnt;
    logic [QPtrW-1:0] n_wr;
    logic [QPtrW-1:0] n_rd;
    logic [QCntW-1:0] n_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == QCntW'(QDepth));
    assign o_qstat.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_qent;
        end
    end

endmodule

[rtl/lghf_div.sv]
// ----------------------------------------------------------------------------
// lghf_div: serial restoring divider
// One quotient bit per cycle; done pulses with quotient and remainder.
// ----------------------------------------------------------------------------
module lghf_div #(
    parameter int unsigned DVW = 53,
    parameter int unsigned VW  = 22
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_dividend,
    input  logic [VW-1:0]  i_divisor,
    output logic           o_done,
    output logic [DVW-1:0] o_quo,
    output logic [VW-1:0]  o_rem
);

    localparam int unsigned CntW = $clog2(DVW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [DVW-1:0]  r_quo;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_dvs;
    logic [DVW-1:0]  n_quo;
    logic [VW-1:0]   n_rem;
    logic [VW:0]     trial;
    logic [VW:0]     diff;
    logic            ge;

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    always_comb begin
        trial = {r_rem, r_quo[DVW-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[VW-1:0] : trial[VW-1:0];
        n_quo = {r_quo[DVW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(DVW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

endmodule

[rtl/lghf_back.sv]
// ----------------------------------------------------------------------------
// lghf_back: accumulation, cut level sequencer and filtering
// Pops classified words, sums low heights, derives the cut level through
// the shared serial divider and emits kept points.
// ----------------------------------------------------------------------------
module lghf_back import lghf_pkg::*; #(
    parameter int unsigned MAX_POINTS = 1048576
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_qent     i_head,
    input  t_qstat    i_qstat,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
    localparam int unsigned SW   = CW + 16;
    localparam int unsigned QW   = CW + 32;
    localparam int unsigned DVW  = QW;
    localparam int unsigned VW   = CW + 1;
    localparam int unsigned DevW = QW + 2;
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_POINTS);

    t_bstate                r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic signed [SW-1:0]   r_sum, n_sum;
    logic [QW-1:0]          r_sq, n_sq;
    logic signed [CutW-1:0] r_cut, n_cut;
    logic                   r_cut_ready, n_cut_ready;
    logic                   r_strobe, n_strobe;
    t_out_item              r_out, n_out;
    t_in_item               r_hold, n_hold;
    logic [15:0]            r_a, n_a;
    logic [CW-1:0]          r_r, n_r;
    logic [31:0]            r_asq, n_asq;
    logic [CW+15:0]         r_ar, n_ar;
    logic [2*CW-1:0]        r_rr, n_rr;
    logic [CW+31:0]         r_nasq, n_nasq;
    logic [CW-1:0]          r_rrq, n_rrq;
    logic [QW-1:0]          r_m2, n_m2;
    logic signed [CutW-1:0] r_mean256, n_mean256;

    logic                   div_start;
    logic [DVW-1:0]         div_dividend;
    logic [VW-1:0]          div_divisor;
    logic                   div_done;
    logic [DVW-1:0]         div_quo;
    logic [VW-1:0]          div_rem;

    t_in_item               item;
    logic signed [15:0]     z;
    logic signed [31:0]     zsq;
    logic [CW-1:0]          base_cnt;
    logic signed [SW-1:0]   base_sum;
    logic [QW-1:0]          base_sq;
    logic [SW-1:0]          mag;
    logic signed [DevW-1:0] dev;
    logic signed [CutW-1:0] z256;
    logic signed [CutW-1:0] hz256;
    logic                   rem_nz;

    lghf_div #(
        .DVW (DVW),
        .VW  (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    always_comb begin
        item   = i_head.item;
        z      = item.z_pos;
        zsq    = z * z;
        mag    = SW'(-r_sum);
        rem_nz = (div_rem != '0);
        z256   = {{(CutW - 24){z[15]}}, z, 8'b0};
        hz256  = {{(CutW - 24){r_hold.z_pos[15]}}, r_hold.z_pos, 8'b0};
        dev    = $signed({2'b00, r_sq}) - $signed(DevW'(r_nasq))
               + $signed(DevW'({r_ar, 1'b0})) - $signed(DevW'(r_rrq));

        base_cnt = r_cnt;
        base_sum = r_sum;
        base_sq  = r_sq;

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_sq        = r_sq;
        n_cut       = r_cut;
        n_cut_ready = r_cut_ready;
        n_strobe    = 1'b0;
        n_out       = r_out;
        n_hold      = r_hold;
        n_a         = r_a;
        n_r         = r_r;
        n_asq       = r_asq;
        n_ar        = r_ar;
        n_rr        = r_rr;
        n_nasq      = r_nasq;
        n_rrq       = r_rrq;
        n_m2        = r_m2;
        n_mean256   = r_mean256;

        o_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = DVW'(mag);
        div_divisor  = VW'(r_cnt);

        case (r_state)
            ST_RUN: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    case (i_head.cls)
                        CLS_MEASURE, CLS_NEW_CLOUD: begin
                            if (i_head.cls == CLS_NEW_CLOUD) begin
                                base_cnt    = '0;
                                base_sum    = '0;
                                base_sq     = '0;
                                n_cut       = '0;
                                n_cut_ready = 1'b0;
                            end
                            n_cnt = base_cnt;
                            n_sum = base_sum;
                            n_sq  = base_sq;
                            if (z[15] && (base_cnt < MaxCnt)) begin
                                n_cnt = base_cnt + 1'b1;
                                n_sum = base_sum + SW'(z);
                                n_sq  = base_sq + QW'($unsigned(zsq));
                            end
                        end
                        CLS_SWITCH: begin
                            if (r_cnt < CW'(2)) begin
                                n_cut       = '0;
                                n_cut_ready = 1'b0;
                                n_strobe    = 1'b1;
                                n_out       = '{item.x_pos, item.y_pos, item.z_pos};
                            end else begin
                                n_hold    = item;
                                div_start = 1'b1;
                                n_state   = ST_W_MEAN;
                            end
                        end
                        default: begin
                            if (!r_cut_ready || (z256 < r_cut)) begin
                                n_strobe = 1'b1;
                                n_out    = '{item.x_pos, item.y_pos, item.z_pos};
                            end
                        end
                    endcase
                end
            end
            ST_W_MEAN: begin
                // mean is -ceil(|S|/n); r = S - n*m
                if (div_done) begin
                    n_a     = div_quo[15:0] + 16'(rem_nz);
                    n_r     = rem_nz ? r_cnt - div_rem[CW-1:0] : '0;
                    n_state = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                n_asq   = r_a * r_a;
                n_ar    = r_a * r_r;
                n_rr    = r_r * r_r;
                n_state = ST_MUL_N;
            end
            ST_MUL_N: begin
                n_nasq       = r_cnt * r_asq;
                div_start    = 1'b1;
                div_dividend = DVW'(r_rr);
                n_state      = ST_W_RR;
            end
            ST_W_RR: begin
                if (div_done) begin
                    n_rrq   = div_quo[CW-1:0];
                    n_state = ST_DEV;
                end
            end
            ST_DEV: begin
                n_m2         = dev[DevW-1] ? '0 : dev[QW-1:0];
                div_start    = 1'b1;
                div_dividend = DVW'({mag, 8'b0});
                n_state      = ST_W_M256;
            end
            ST_W_M256: begin
                if (div_done) begin
                    n_mean256 = CutW'(0) - CutW'(div_quo) - CutW'(rem_nz);
                    n_state   = ST_VAR_GO;
                end
            end
            ST_VAR_GO: begin
                div_start    = 1'b1;
                div_dividend = DVW'(r_m2);
                div_divisor  = {r_cnt - 1'b1, 1'b0};
                n_state      = ST_W_VAR;
            end
            ST_W_VAR: begin
                if (div_done) begin
                    n_cut       = r_mean256 + CutW'(div_quo);
                    n_cut_ready = 1'b1;
                    // the switching word is filtered against the new level
                    if (hz256 < n_cut) begin
                        n_strobe = 1'b1;
                        n_out    = '{r_hold.x_pos, r_hold.y_pos, r_hold.z_pos};
                    end
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_cut       <= '0;
            r_cut_ready <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_sq        <= n_sq;
            r_cut       <= n_cut;
            r_cut_ready <= n_cut_ready;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_hold    <= n_hold;
        r_a       <= n_a;
        r_r       <= n_r;
        r_asq     <= n_asq;
        r_ar      <= n_ar;
        r_rr      <= n_rr;
        r_nasq    <= n_nasq;
        r_rrq     <= n_rrq;
        r_m2      <= n_m2;
        r_mean256 <= n_mean256;
    end

endmodule

[rtl/lidar_ground_height_filter.sv]
// ----------------------------------------------------------------------------
// lidar_ground_height_filter: two-pass lidar ground height filter
// A kept filter word is queued, popped and registered to the strobe; no result stall.
// One word per cycle while the queue is not full; a pass switch stalls pops for the divider.
// Sync reset clears the sums and the cut level and starts a measure pass.
// ----------------------------------------------------------------------------
module lidar_ground_height_filter import lghf_pkg::*; #(
    parameter int unsigned MAX_POINTS = 1048576
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    logic   push;
    logic   pop;
    t_qent  qent;
    t_qent  head;
    t_qstat qstat;

    lghf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .i_qstat (qstat),
        .o_busy  (o_busy),
        .o_push  (push),
        .o_qent  (qent)
    );

    lghf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_qent  (qent),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    lghf_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
